[rtl/mexp_pkg.sv]
`default_nettype none
package mexp_pkg;

    localparam int WIDTH    = 32;
    localparam int EXP_BITS = 32;
    localparam int CNT_W    = $clog2(WIDTH + 1);
    localparam int EBIT_W   = $clog2(EXP_BITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL,
        ST_SQR,
        ST_NEXT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic red_start;
        logic mul_start;
        logic sqr_start;
        logic exp_adv;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_zero;
        logic exp_bit;
        logic exp_last;
        logic mm_done;
    } t_status;

endpackage
`default_nettype wire

[rtl/mexp_datapath.sv]
`default_nettype none
module mexp_datapath
    import mexp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    input  wire logic [WIDTH-1:0] i_modulus,
    input  wire logic [WIDTH-1:0] i_base,
    input  wire logic [EXP_BITS-1:0] i_exponent,
    output t_status               o_status,
    output logic [WIDTH-1:0]      o_power
);

    // shift-and-add modular multiplier, one multiplier bit per cycle;
    // reduction of the base is 1*base run over all bits of the base
    logic [WIDTH-1:0]    r_acc, n_acc;
    logic [WIDTH-1:0]    r_sq;
    logic [WIDTH-1:0]    r_x, r_y;
    logic [WIDTH-1:0]    r_mm;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic [1:0]          r_dst;
    logic [EXP_BITS-1:0] r_exp;
    logic [EBIT_W-1:0]   r_ebit;
    logic                r_done;

    localparam logic [1:0] DST_SQ  = 2'd0;
    localparam logic [1:0] DST_ACC = 2'd1;

    logic [WIDTH:0] dbl, dbl_r, add, add_r;
    logic [WIDTH:0] m_ext;

    always_comb begin
        m_ext = {1'b0, i_modulus};
        dbl   = {r_mm, 1'b0};
        dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
        add   = dbl_r + {1'b0, r_x};
        add_r = (add >= m_ext) ? add - m_ext : add;
    end

    // base reduction: operand x must be < m; feed base through the loop as
    // y with x = 1 mod m, which yields base mod m
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.red_start) begin
                r_x    <= (i_modulus == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0
                                                                   : {{(WIDTH-1){1'b0}}, 1'b1};
                r_y    <= i_base;
                r_mm   <= '0;
                r_cnt  <= CNT_W'(WIDTH);
                r_busy <= 1'b1;
                r_dst  <= DST_SQ;
            end else if (i_cmd.mul_start || i_cmd.sqr_start) begin
                r_x    <= r_sq;
                r_y    <= i_cmd.mul_start ? r_acc : r_sq;
                r_mm   <= '0;
                r_cnt  <= CNT_W'(WIDTH);
                r_busy <= 1'b1;
                r_dst  <= i_cmd.mul_start ? DST_ACC : DST_SQ;
            end else if (r_busy) begin
                r_mm  <= r_y[WIDTH-1] ? add_r[WIDTH-1:0] : dbl_r[WIDTH-1:0];
                r_y   <= {r_y[WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.load)
            n_acc = {{(WIDTH-1){1'b0}}, 1'b1};
        else if (r_done && r_dst == DST_ACC)
            n_acc = r_mm;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (r_done && r_dst == DST_SQ)
            r_sq <= r_mm;
        if (i_cmd.load) begin
            r_exp  <= i_exponent;
            r_ebit <= '0;
        end else if (i_cmd.exp_adv) begin
            r_exp  <= r_exp >> 1;
            r_ebit <= r_ebit + 1'b1;
        end
    end

    assign o_status.mod_zero = (i_modulus == '0);
    assign o_status.exp_bit  = r_exp[0];
    assign o_status.exp_last = (r_ebit == EBIT_W'(EXP_BITS - 1)) || ((r_exp >> 1) == '0);
    assign o_status.mm_done  = r_done;
    assign o_power           = r_acc;

    done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy multiply");

    no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_cmd.mul_start || i_cmd.sqr_start || i_cmd.red_start)
        |-> !(i_cmd.mul_start || i_cmd.sqr_start || i_cmd.red_start))
        else $error("multiply restarted while busy");

    residue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && i_modulus != '0 |-> r_mm < i_modulus)
        else $error("residue not below modulus");

endmodule
`default_nettype wire

[rtl/mexp_ctrl.sv]
`default_nettype none
module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy,
    output logic         o_valid,
    output logic         o_zero
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_valid = 1'b0;
        o_zero  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.mod_zero) begin
                        o_valid = 1'b1;
                        o_zero  = 1'b1;
                    end else begin
                        o_cmd.red_start = 1'b1;
                        n_state = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                if (i_status.mm_done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (i_status.exp_bit) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = ST_MUL;
                end else if (i_status.exp_last) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.sqr_start = 1'b1;
                    n_state = ST_SQR;
                end
            end
            ST_MUL: begin
                if (i_status.mm_done) begin
                    if (i_status.exp_last) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.sqr_start = 1'b1;
                        n_state = ST_SQR;
                    end
                end
            end
            ST_SQR: begin
                if (i_status.mm_done) begin
                    o_cmd.exp_adv = 1'b1;
                    n_state = ST_NEXT;
                end
            end
            ST_DONE: begin
                o_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    done_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> r_state == ST_IDLE) else $error("done not followed by idle");

    valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> r_state == ST_IDLE) else $error("result outside idle return");

    start_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_start |-> !o_cmd.sqr_start) else $error("two multiplies started");

endmodule
`default_nettype wire

[rtl/modular_exponentiation_top.sv]
// modular exponentiation, right-to-left square and multiply. write the
// modulus (reset 1) at address 0 over the apb-style port while the block
// is idle. a request is taken when i_start is high and o_busy is low;
// the result appears on o_power for exactly one cycle with o_valid high
// and cannot be stalled, so the receiver must take it then. all arithmetic
// runs on one shared shift-and-add modular multiplier doing one bit per
// cycle: the base is reduced first, then every exponent bit below the
// highest set one costs a step through ST_NEXT plus a square, and each
// set bit adds a multiply. a zero modulus answers 0 in the cycle right
// after the request is taken.
`default_nettype none
module modular_exponentiation_top
    import mexp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_base,
    input  wire logic [31:0] i_exponent,
    output logic             o_valid,
    output logic [31:0]      o_power,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [1:0] ADDR_MODULUS = 2'd0;

    logic [WIDTH-1:0] r_modulus;
    t_cmd             cmd;
    t_status          status;
    logic [WIDTH-1:0] power;
    logic             valid, zero, busy;
    logic             r_valid;
    logic [31:0]      r_power;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= {{(WIDTH-1){1'b0}}, 1'b1};
        end else if (psel && penable && pwrite && paddr == ADDR_MODULUS) begin
            r_modulus <= pwdata[WIDTH-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULUS) ? r_modulus : '0;

    mexp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (valid),
        .o_zero   (zero)
    );

    mexp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_modulus  (r_modulus),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .o_status   (status),
        .o_power    (power)
    );

    // result register, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= valid;
        if (valid) r_power <= zero ? '0 : power;
    end

    assign o_busy  = busy;
    assign o_valid = r_valid;
    assign o_power = r_power;

    one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !valid |=> !r_valid) else $error("result strobe without a finished request");

    zero_mod_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        valid && zero |=> r_power == '0) else $error("zero modulus result nonzero");

    busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_modulus) || $past(psel && penable && pwrite))
        else $error("modulus changed unexpectedly");

endmodule
`default_nettype wire
